// ===== rtl/urrb_pkg.sv =====
// Shared constants for the UART receive/transmit ring buffer core.
`default_nettype none

package urrb_pkg;

    // Ring depths
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;

    // Derived widths
    localparam int RX_IDX_W = $clog2(RX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH);       // holds up to RX_DEPTH-1
    localparam int TX_IDX_W = $clog2(TX_DEPTH);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);   // holds up to TX_DEPTH

    // Event kinds
    localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
    localparam logic [2:0] KIND_POP      = 3'd1;
    localparam logic [2:0] KIND_PEEK     = 3'd2;
    localparam logic [2:0] KIND_SW_WRITE = 3'd3;
    localparam logic [2:0] KIND_TX_READY = 3'd4;

endpackage : urrb_pkg

`default_nettype wire

// ===== rtl/uart_rx_tx_ring_buffers_core.sv =====
// Top level of the UART receive/transmit ring buffer core.
`default_nettype none

// UART byte buffering core: one event beat in, one result beat out. Events are
// a received line byte, a pop or a peek of the receive ring, a software write
// and a transmitter-ready strobe. The core takes one beat per cycle unless a
// result is stalled; its result, read through the registered RAM read port,
// appears in the next cycle. State (heads, counts, flags) is updated at the
// accepting edge, and the fill/flag fields of the result are driven straight
// from it, since no further beat is accepted while a result is stalled. An
// output register separates the two sides: a new beat is taken while the
// current result is being taken. The receive ring keeps one valid bit per
// entry so a peek of a never-written slot reads 0 right after reset; the
// transmit ring needs no clearing, so the core is ready straight out of reset.
// Receive ring holds at most RX_DEPTH-1 bytes; transmit ring holds TX_DEPTH.
module uart_rx_tx_ring_buffers_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // event input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], line_error[8], tx_reg_free[9]
    input  wire logic [2:0]  s_axis_tuser,  // kind[2:0]
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata   // read_byte[7:0], send_valid[8],
                                            // send_byte[16:9], receiver_restart[17],
                                            // rx_fill[23:18], tx_fill[30:24],
                                            // tx_overflowed[31], tx_irq_on[32]
);

    localparam int RX_IDX_W = urrb_pkg::RX_IDX_W;
    localparam int RX_CNT_W = urrb_pkg::RX_CNT_W;
    localparam int TX_IDX_W = urrb_pkg::TX_IDX_W;
    localparam int TX_CNT_W = urrb_pkg::TX_CNT_W;

    // input beat fields
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       line_error;
    logic       tx_reg_free;
    logic       in_fire;

    // ring state
    logic [RX_IDX_W-1:0]        rx_head_reg, rx_head_next;
    logic [RX_CNT_W-1:0]        rx_count_reg, rx_count_next;
    logic [urrb_pkg::RX_DEPTH-1:0] rx_valid_reg, rx_valid_next;
    logic [TX_IDX_W-1:0]        tx_head_reg, tx_head_next;
    logic [TX_CNT_W-1:0]        tx_count_reg, tx_count_next;
    logic                       tx_lost_reg, tx_lost_next;
    logic                       tx_irq_reg, tx_irq_next;

    // result register
    logic       out_valid_reg;
    logic       rd_sel_reg, rd_sel_next;       // read_byte comes from rx memory
    logic       send_valid_reg, send_valid_next;
    logic       send_ram_reg, send_ram_next;   // send_byte comes from tx memory
    logic [7:0] send_byte_reg, send_byte_next;
    logic       restart_reg, restart_next;

    // slot arithmetic
    logic [RX_IDX_W:0]   rx_sum;
    logic [RX_IDX_W-1:0] rx_wr_slot;
    logic [RX_IDX_W-1:0] rx_head_inc;
    logic [TX_IDX_W:0]   tx_sum;
    logic [TX_IDX_W-1:0] tx_wr_slot;
    logic [TX_IDX_W-1:0] tx_head_inc;

    // memory ports
    logic       rx_we, rx_re, tx_we, tx_re;
    logic [7:0] rx_rdata, tx_rdata;

    logic [7:0] read_byte;
    logic [7:0] send_byte;

    assign kind        = s_axis_tuser;
    assign data_byte   = s_axis_tdata[7:0];
    assign line_error  = s_axis_tdata[8];
    assign tx_reg_free = s_axis_tdata[9];

    // input taken whenever the result slot is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // write slot = head + count, wrapped at ring depth
    always_comb
    begin
        rx_sum = {1'b0, rx_head_reg} + (RX_IDX_W + 1)'(rx_count_reg);
        if (rx_sum >= (RX_IDX_W + 1)'(urrb_pkg::RX_DEPTH))
            rx_sum = rx_sum - (RX_IDX_W + 1)'(urrb_pkg::RX_DEPTH);
        rx_wr_slot = rx_sum[RX_IDX_W-1:0];

        if ({1'b0, rx_head_reg} == (RX_IDX_W + 1)'(urrb_pkg::RX_DEPTH - 1))
            rx_head_inc = '0;
        else
            rx_head_inc = rx_head_reg + RX_IDX_W'(1);

        tx_sum = {1'b0, tx_head_reg} + (TX_IDX_W + 1)'(tx_count_reg);
        if (tx_sum >= (TX_IDX_W + 1)'(urrb_pkg::TX_DEPTH))
            tx_sum = tx_sum - (TX_IDX_W + 1)'(urrb_pkg::TX_DEPTH);
        tx_wr_slot = tx_sum[TX_IDX_W-1:0];

        if ({1'b0, tx_head_reg} == (TX_IDX_W + 1)'(urrb_pkg::TX_DEPTH - 1))
            tx_head_inc = '0;
        else
            tx_head_inc = tx_head_reg + TX_IDX_W'(1);
    end

    // event decode
    always_comb
    begin
        rx_head_next    = rx_head_reg;
        rx_count_next   = rx_count_reg;
        rx_valid_next   = rx_valid_reg;
        tx_head_next    = tx_head_reg;
        tx_count_next   = tx_count_reg;
        tx_lost_next    = tx_lost_reg;
        tx_irq_next     = tx_irq_reg;
        rd_sel_next     = 1'b0;
        send_valid_next = 1'b0;
        send_ram_next   = 1'b0;
        send_byte_next  = 8'd0;
        restart_next    = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;

        unique case (kind)
            urrb_pkg::KIND_RX_BYTE:
            begin
                if (line_error)
                    restart_next = 1'b1;
                else if (rx_count_reg < RX_CNT_W'(urrb_pkg::RX_DEPTH - 1))
                begin
                    rx_we                     = 1'b1;
                    rx_valid_next[rx_wr_slot] = 1'b1;
                    rx_count_next             = rx_count_reg + RX_CNT_W'(1);
                end
            end
            urrb_pkg::KIND_POP:
            begin
                if (rx_count_reg != '0)
                begin
                    rx_re         = 1'b1;
                    rd_sel_next   = 1'b1;
                    rx_head_next  = rx_head_inc;
                    rx_count_next = rx_count_reg - RX_CNT_W'(1);
                end
            end
            urrb_pkg::KIND_PEEK:
            begin
                // a never-written slot reads as zero
                rx_re       = 1'b1;
                rd_sel_next = rx_valid_reg[rx_head_reg];
            end
            urrb_pkg::KIND_SW_WRITE:
            begin
                if (tx_count_reg == '0 && tx_reg_free)
                begin
                    send_valid_next = 1'b1;
                    send_byte_next  = data_byte;
                end
                else
                begin
                    if (tx_count_reg < TX_CNT_W'(urrb_pkg::TX_DEPTH))
                    begin
                        tx_we         = 1'b1;
                        tx_count_next = tx_count_reg + TX_CNT_W'(1);
                    end
                    else
                        tx_lost_next = 1'b1;
                    tx_irq_next = 1'b1;
                end
            end
            urrb_pkg::KIND_TX_READY:
            begin
                if (tx_count_reg == '0)
                    tx_irq_next = 1'b0;
                else
                begin
                    tx_re           = 1'b1;
                    send_valid_next = 1'b1;
                    send_ram_next   = 1'b1;
                    tx_head_next    = tx_head_inc;
                    tx_count_next   = tx_count_reg - TX_CNT_W'(1);
                end
            end
            default:
            begin
                // unused kinds: report state only
            end
        endcase
    end

    // ring state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_count_reg  <= '0;
            rx_valid_reg  <= '0;
            tx_head_reg   <= '0;
            tx_count_reg  <= '0;
            tx_lost_reg   <= 1'b0;
            tx_irq_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                rx_head_reg  <= rx_head_next;
                rx_count_reg <= rx_count_next;
                rx_valid_reg <= rx_valid_next;
                tx_head_reg  <= tx_head_next;
                tx_count_reg <= tx_count_next;
                tx_lost_reg  <= tx_lost_next;
                tx_irq_reg   <= tx_irq_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_sel_reg     <= rd_sel_next;
            send_valid_reg <= send_valid_next;
            send_ram_reg   <= send_ram_next;
            send_byte_reg  <= send_byte_next;
            restart_reg    <= restart_next;
        end
    end

    urrb_ram #(
        .WIDTH (8),
        .DEPTH (urrb_pkg::RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (in_fire && rx_we),
        .waddr (rx_wr_slot),
        .wdata (data_byte),
        .re    (in_fire && rx_re),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    urrb_ram #(
        .WIDTH (8),
        .DEPTH (urrb_pkg::TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (in_fire && tx_we),
        .waddr (tx_wr_slot),
        .wdata (data_byte),
        .re    (in_fire && tx_re),
        .raddr (tx_head_reg),
        .rdata (tx_rdata)
    );

    // memory read data holds while the result stalls
    assign read_byte = rd_sel_reg ? rx_rdata : 8'd0;
    assign send_byte = send_ram_reg ? tx_rdata : send_byte_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            tx_irq_reg,
                            tx_lost_reg,
                            7'(tx_count_reg),
                            6'(rx_count_reg),
                            restart_reg,
                            send_byte,
                            send_valid_reg,
                            read_byte};

endmodule : uart_rx_tx_ring_buffers_core

`default_nettype wire

// ===== rtl/urrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : urrb_ram

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the UART receive/transmit ring buffer core, with a self-checking ring mirror.
`timescale 1ns / 100ps

module tb_top;

    // Spare kinds: no state change, result just reports fills and flags
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    // Unpacked view of one result beat
    typedef struct packed {
        logic [7:0]                    read_byte;
        logic                          send_valid;
        logic [7:0]                    send_byte;
        logic                          receiver_restart;
        logic [urrb_pkg::RX_CNT_W-1:0] rx_fill;
        logic [urrb_pkg::TX_CNT_W-1:0] tx_fill;
        logic                          tx_overflowed;
        logic                          tx_irq_on;
    } core_result_t;

    // Traffic mix of one random stretch
    typedef enum {
        PH_RX_FILL,
        PH_RX_DRAIN,
        PH_TX_FILL,
        PH_TX_DRAIN,
        PH_MIXED
    } phase_t;

    // Mirror of both rings: predicts the result of every accepted event beat
    // and matches the core's result beats against them in order.
    class uart_rings_mirror;
        bit [7:0]     rx_ring [urrb_pkg::RX_DEPTH];
        bit [7:0]     tx_ring [urrb_pkg::TX_DEPTH];
        int           rx_first;
        int           rx_held;
        int           tx_first;
        int           tx_held;
        bit           tx_lost;
        bit           tx_irq;
        core_result_t owed_beats [$];
        int unsigned  faults;
        int unsigned  kind_seen [8];
        int unsigned  line_errors;
        int unsigned  rx_full_drops;
        int unsigned  tx_losses;
        int unsigned  direct_sends;

        function void take_event(logic [2:0] kind, logic [7:0] val, logic err, logic free);
            core_result_t r;
            r = '0;
            kind_seen[kind]++;
            case (kind)
                urrb_pkg::KIND_RX_BYTE:
                    if (err) begin
                        r.receiver_restart = 1'b1;
                        line_errors++;
                    end else if (rx_held < urrb_pkg::RX_DEPTH - 1) begin
                        rx_ring[(rx_first + rx_held) % urrb_pkg::RX_DEPTH] = val;
                        rx_held++;
                    end else begin
                        // one slot always stays free; the byte vanishes silently
                        rx_full_drops++;
                    end
                urrb_pkg::KIND_POP:
                    if (rx_held > 0) begin
                        r.read_byte = rx_ring[rx_first];
                        rx_first    = (rx_first + 1) % urrb_pkg::RX_DEPTH;
                        rx_held--;
                    end
                urrb_pkg::KIND_PEEK:
                    r.read_byte = rx_ring[rx_first];   // stale slot when empty
                urrb_pkg::KIND_SW_WRITE:
                    if (tx_held == 0 && free) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = val;
                        direct_sends++;
                    end else begin
                        if (tx_held < urrb_pkg::TX_DEPTH) begin
                            tx_ring[(tx_first + tx_held) % urrb_pkg::TX_DEPTH] = val;
                            tx_held++;
                        end else begin
                            tx_lost = 1'b1;
                            tx_losses++;
                        end
                        tx_irq = 1'b1;
                    end
                urrb_pkg::KIND_TX_READY:
                    if (tx_held == 0) begin
                        tx_irq = 1'b0;
                    end else begin
                        r.send_valid = 1'b1;
                        r.send_byte  = tx_ring[tx_first];
                        tx_first     = (tx_first + 1) % urrb_pkg::TX_DEPTH;
                        tx_held--;
                    end
                default: ;
            endcase
            r.rx_fill       = rx_held[urrb_pkg::RX_CNT_W-1:0];
            r.tx_fill       = tx_held[urrb_pkg::TX_CNT_W-1:0];
            r.tx_overflowed = tx_lost;
            r.tx_irq_on     = tx_irq;
            owed_beats.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                faults++;
            end
        endfunction

        function void compare_beat(logic [39:0] beat);
            core_result_t want;
            if (owed_beats.size() == 0) begin
                $error("result beat 0x%h arrived with no event outstanding", beat);
                faults++;
                return;
            end
            want = owed_beats.pop_front();
            check_field("read_byte",        want.read_byte,        beat[7:0]);
            check_field("send_valid",       want.send_valid,       beat[8]);
            check_field("send_byte",        want.send_byte,        beat[16:9]);
            check_field("receiver_restart", want.receiver_restart, beat[17]);
            check_field("rx_fill",          want.rx_fill,          beat[23:18]);
            check_field("tx_fill",          want.tx_fill,          beat[30:24]);
            check_field("tx_overflowed",    want.tx_overflowed,    beat[31]);
            check_field("tx_irq_on",        want.tx_irq_on,        beat[32]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // data_byte[7:0], line_error[8], tx_reg_free[9]
    logic [2:0]  s_axis_tuser = '0;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // read_byte, send_valid, send_byte, receiver_restart,
                                      // rx_fill, tx_fill, tx_overflowed, tx_irq_on

    uart_rings_mirror rings;
    bit               quiet_phase = 1'b0;   // no gaps or stalls while set
    int unsigned      events_sent = 0;

    uart_rx_tx_ring_buffers_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Event beats in, result beats out; both sampled at the same edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                rings.take_event(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                                 s_axis_tdata[9]);
            if (m_axis_tvalid && m_axis_tready)
                rings.compare_beat(m_axis_tdata);
        end
    end

    // Result side back-pressure
    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    hold = idle_len();
            end
        end
    end

    // Present one event beat and hold it until the core takes it
    task automatic send_event(input logic [2:0] kind, input logic [7:0] val,
                              input logic err, input logic free);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, free, err, val};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic run_phase(input phase_t mode, input int len);
        int         r;
        logic [2:0] kind;
        repeat (len) begin
            r = $urandom_range(0, 99);
            case (mode)
                PH_RX_FILL:
                    kind = r < 70 ? urrb_pkg::KIND_RX_BYTE : r < 85 ? urrb_pkg::KIND_POP :
                           r < 92 ? urrb_pkg::KIND_PEEK :
                           r < 96 ? urrb_pkg::KIND_SW_WRITE : urrb_pkg::KIND_TX_READY;
                PH_RX_DRAIN:
                    kind = r < 60 ? urrb_pkg::KIND_POP : r < 75 ? urrb_pkg::KIND_PEEK :
                           r < 90 ? urrb_pkg::KIND_RX_BYTE :
                           r < 95 ? urrb_pkg::KIND_SW_WRITE : urrb_pkg::KIND_TX_READY;
                PH_TX_FILL:
                    kind = r < 70 ? urrb_pkg::KIND_SW_WRITE :
                           r < 82 ? urrb_pkg::KIND_TX_READY :
                           r < 92 ? urrb_pkg::KIND_RX_BYTE : urrb_pkg::KIND_POP;
                PH_TX_DRAIN:
                    kind = r < 60 ? urrb_pkg::KIND_TX_READY :
                           r < 80 ? urrb_pkg::KIND_SW_WRITE :
                           r < 90 ? urrb_pkg::KIND_RX_BYTE : urrb_pkg::KIND_PEEK;
                default:
                    kind = r < 95 ?
                        3'($urandom_range(urrb_pkg::KIND_RX_BYTE, urrb_pkg::KIND_TX_READY)) :
                        3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            endcase
            send_event(kind, 8'($urandom), $urandom_range(0, 99) < 8, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        phase_t mode;
        int     len;
        rings = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-ring reads, byte extremes, line error, direct and
        // queued sends, ready on an empty ring, spare kinds
        send_event(urrb_pkg::KIND_PEEK,     8'hFF, 1'b1, 1'b1);  // nothing written yet: 0
        send_event(urrb_pkg::KIND_POP,      8'hFF, 1'b0, 1'b0);  // empty pop
        send_event(urrb_pkg::KIND_RX_BYTE,  8'h00, 1'b0, 1'b1);
        send_event(urrb_pkg::KIND_RX_BYTE,  8'hFF, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_RX_BYTE,  8'hA5, 1'b1, 1'b0);  // line error, dropped
        send_event(urrb_pkg::KIND_PEEK,     8'h00, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_POP,      8'h00, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_POP,      8'h00, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_POP,      8'h00, 1'b0, 1'b0);  // empty again
        send_event(urrb_pkg::KIND_PEEK,     8'h00, 1'b0, 1'b0);  // never-written slot: 0
        send_event(urrb_pkg::KIND_TX_READY, 8'hFF, 1'b1, 1'b1);  // nothing queued
        send_event(urrb_pkg::KIND_SW_WRITE, 8'h00, 1'b0, 1'b1);  // straight to register
        send_event(urrb_pkg::KIND_SW_WRITE, 8'hFF, 1'b1, 1'b0);  // register busy: queued
        send_event(urrb_pkg::KIND_SW_WRITE, 8'h5A, 1'b0, 1'b1);  // ring not empty: queued
        send_event(urrb_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0);
        send_event(urrb_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0);  // drains, irq off
        send_event(KIND_SPARE_FIRST,        8'hFF, 1'b1, 1'b1);
        send_event(KIND_SPARE_MID,          8'h3C, 1'b0, 1'b1);
        send_event(KIND_SPARE_LAST,         8'hFF, 1'b1, 1'b0);

        // Random stretches, each leaning toward filling or draining one ring, or mixed
        while (events_sent < 1450) begin
            mode        = phase_t'($urandom_range(PH_RX_FILL, PH_MIXED));
            quiet_phase = ($urandom_range(0, 3) == 0);
            len         = $urandom_range(40, 180);
            if (events_sent + len > 1450)
                len = 1450 - events_sent;
            run_phase(mode, len);
        end
        quiet_phase = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (rings.owed_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d events: %0d line bytes, %0d pops, %0d peeks, %0d writes, %0d ready",
                 events_sent, rings.kind_seen[urrb_pkg::KIND_RX_BYTE],
                 rings.kind_seen[urrb_pkg::KIND_POP], rings.kind_seen[urrb_pkg::KIND_PEEK],
                 rings.kind_seen[urrb_pkg::KIND_SW_WRITE],
                 rings.kind_seen[urrb_pkg::KIND_TX_READY]);
        $display("Line errors %0d, rx ring-limit drops %0d, tx ring losses %0d, direct sends %0d",
                 rings.line_errors, rings.rx_full_drops, rings.tx_losses, rings.direct_sends);
        if (rings.faults == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/urrb_pkg.sv
rtl/urrb_ram.sv
rtl/uart_rx_tx_ring_buffers_core.sv
bench/tb_top.sv
